@@ hw/rtl/rotation_matrix_to_quaternion_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the rotation matrix to quaternion block
// Short wrappers that keep the checker's properties on one line each.
// ---------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// Checked on every edge, also during reset: the consequent lands in the next cycle.
`define RMQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rmq assertion failed");

// Checked out of reset: the consequent holds in the same cycle.
`define RMQ_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmq assertion failed");

// Checked out of reset: the consequent holds after the delay given as n.
`define RMQ_ASSERT_DELAY(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("rmq assertion failed");

`endif

@@ hw/rtl/rmq_pkg.sv @@
// ---------------------------------------------------------------------------
// rmq_pkg
// Shared constants, axis codes, width helpers and the latency helper of the quaternion block.
// ---------------------------------------------------------------------------
package rmq_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int QUEUE_DEPTH    = 2;

  // Quaternion component slots; also names the component that takes the root.
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2,
    AXIS_W = 2'd3
  } axis_t;

  // Width of the non-negative radicand in fixed point.
  function automatic int rad_width(int dw, int fb);
    return ((dw > fb) ? dw : fb) + 3;
  endfunction

  // Bits of the square root of radicand << fb.
  function automatic int root_width(int dw, int fb);
    return (rad_width(dw, fb) + fb + 1) >> 1;
  endfunction

  // Width of one numerator: a sum or difference of two entries.
  function automatic int num_width(int dw);
    return dw + 1;
  endfunction

  // Width of one queued item: root slot, radicand, four numerators.
  function automatic int item_width(int dw, int fb);
    return 2 + rad_width(dw, fb) + 4 * num_width(dw);
  endfunction

  // Cycles from the accepting edge to the edge that takes the result.
  function automatic int latency(int dw, int fb);
    return 4 + root_width(dw, fb) + 2 * fb;
  endfunction

endpackage

@@ hw/rtl/rmq_front.sv @@
// ---------------------------------------------------------------------------
// rmq_front
// Classifies a matrix beat: picks the branch, forms the radicand and the
// three numerators, and registers the item for the queue.
// ---------------------------------------------------------------------------
module rmq_front #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF,
  localparam int IW = rmq_pkg::item_width(DATA_WIDTH, FRAC_BITS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  logic                         hold,
  input  logic signed [DATA_WIDTH-1:0] in_m00,
  input  logic signed [DATA_WIDTH-1:0] in_m01,
  input  logic signed [DATA_WIDTH-1:0] in_m02,
  input  logic signed [DATA_WIDTH-1:0] in_m10,
  input  logic signed [DATA_WIDTH-1:0] in_m11,
  input  logic signed [DATA_WIDTH-1:0] in_m12,
  input  logic signed [DATA_WIDTH-1:0] in_m20,
  input  logic signed [DATA_WIDTH-1:0] in_m21,
  input  logic signed [DATA_WIDTH-1:0] in_m22,
  output logic                         item_valid,
  output logic [IW-1:0]                item
);
  import rmq_pkg::*;

  localparam int RAD_W = rad_width(DATA_WIDTH, FRAC_BITS);
  localparam int VW    = num_width(DATA_WIDTH);
  localparam int EW    = RAD_W + 1;
  localparam logic signed [EW-1:0] ONE_C = {{(EW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  logic signed [VW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [EW-1:0] tr, rad_s;
  logic signed [VW-1:0] v [4];
  logic [RAD_W-1:0]     rad_u;
  axis_t                idx, pos;
  logic                 valid_r;
  logic [IW-1:0]        item_r, item_nxt;

  assign e00 = VW'(in_m00);
  assign e01 = VW'(in_m01);
  assign e02 = VW'(in_m02);
  assign e10 = VW'(in_m10);
  assign e11 = VW'(in_m11);
  assign e12 = VW'(in_m12);
  assign e20 = VW'(in_m20);
  assign e21 = VW'(in_m21);
  assign e22 = VW'(in_m22);

  always_comb begin
    tr  = EW'(e00) + EW'(e11) + EW'(e22);
    idx = AXIS_X;
    if (e11 > e00) idx = AXIS_Y;
    if (e22 > ((idx == AXIS_Y) ? e11 : e00)) idx = AXIS_Z;
    for (int n = 0; n < 4; n++) v[n] = '0;
    pos   = AXIS_W;
    rad_s = '0;
    if (tr > 0) begin
      pos   = AXIS_W;
      rad_s = tr + ONE_C;
      v[0]  = e12 - e21;
      v[1]  = e20 - e02;
      v[2]  = e01 - e10;
    end else begin
      case (idx)
        AXIS_X: begin
          pos   = AXIS_X;
          rad_s = EW'(e00) - (EW'(e11) + EW'(e22)) + ONE_C;
          v[3]  = e12 - e21;
          v[1]  = e01 + e10;
          v[2]  = e02 + e20;
        end
        AXIS_Y: begin
          pos   = AXIS_Y;
          rad_s = EW'(e11) - (EW'(e22) + EW'(e00)) + ONE_C;
          v[3]  = e20 - e02;
          v[2]  = e12 + e21;
          v[0]  = e10 + e01;
        end
        AXIS_Z: begin
          pos   = AXIS_Z;
          rad_s = EW'(e22) - (EW'(e00) + EW'(e11)) + ONE_C;
          v[3]  = e01 - e10;
          v[0]  = e20 + e02;
          v[1]  = e21 + e12;
        end
        default: begin
          pos   = AXIS_W;
          rad_s = '0;
        end
      endcase
    end
    // A radicand at or below zero gives a zero root.
    rad_u    = (rad_s > 0) ? rad_s[RAD_W-1:0] : '0;
    item_nxt = {pos, rad_u, v[3], v[2], v[1], v[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!hold) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold && load) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ hw/rtl/rmq_queue.sv @@
// ---------------------------------------------------------------------------
// rmq_queue
// Short register queue between the classifier and the arithmetic back end.
// ---------------------------------------------------------------------------
module rmq_queue #(
  parameter int IW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [IW-1:0] push_item,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output logic [IW-1:0] head_item
);
  import rmq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [IW-1:0]    slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= PTR_W'((32'(wr_ptr_r) + 1) % QUEUE_DEPTH);
      if (do_pop)  rd_ptr_r <= PTR_W'((32'(rd_ptr_r) + 1) % QUEUE_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

@@ hw/rtl/rmq_back.sv @@
// ---------------------------------------------------------------------------
// rmq_back
// Arithmetic back end: pipelined square root, pipelined reciprocal, four
// scaling multipliers and saturation into the result register.
// ---------------------------------------------------------------------------
module rmq_back #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF,
  localparam int IW = rmq_pkg::item_width(DATA_WIDTH, FRAC_BITS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_valid,
  input  logic [IW-1:0]                item,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_quat_x,
  output logic signed [DATA_WIDTH-1:0] out_quat_y,
  output logic signed [DATA_WIDTH-1:0] out_quat_z,
  output logic signed [DATA_WIDTH-1:0] out_quat_w
);
  import rmq_pkg::*;

  localparam int RAD_W  = rad_width(DATA_WIDTH, FRAC_BITS);
  localparam int ROOT_W = root_width(DATA_WIDTH, FRAC_BITS);
  localparam int SQ_W   = 2 * ROOT_W;
  localparam int VW     = num_width(DATA_WIDTH);
  localparam int PW     = 2 + 4 * VW;
  localparam int Q_W    = 2 * FRAC_BITS;
  localparam int PR_W   = VW + Q_W;
  localparam logic [63:0] MAXP = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;

  // Square root, two radicand bits per stage.
  logic              sq_valid_r [ROOT_W];
  logic [ROOT_W+1:0] sq_rem_r   [ROOT_W];
  logic [ROOT_W-1:0] sq_root_r  [ROOT_W];
  logic [SQ_W-1:0]   sq_n_r     [ROOT_W];
  logic [PW-1:0]     sq_pay_r   [ROOT_W];

  logic [SQ_W-1:0] rad_pad;
  assign rad_pad = SQ_W'({item[IW-3 -: RAD_W], {FRAC_BITS{1'b0}}});

  genvar k;
  for (k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic              pv;
    logic [ROOT_W+1:0] prem, rem_in, trial;
    logic [ROOT_W-1:0] proot;
    logic [SQ_W-1:0]   pn;
    logic [PW-1:0]     ppay;
    logic              ge;
    if (k == 0) begin : g_first
      assign pv    = item_valid;
      assign prem  = '0;
      assign proot = '0;
      assign pn    = rad_pad;
      assign ppay  = {item[IW-1 -: 2], item[4*VW-1:0]};
    end else begin : g_next
      assign pv    = sq_valid_r[k-1];
      assign prem  = sq_rem_r[k-1];
      assign proot = sq_root_r[k-1];
      assign pn    = sq_n_r[k-1];
      assign ppay  = sq_pay_r[k-1];
    end
    assign rem_in = {prem[ROOT_W-1:0], pn[SQ_W-1 -: 2]};
    assign trial  = {proot, 2'b01};
    assign ge     = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_valid_r[k] <= 1'b0;
      end else begin
        sq_valid_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      sq_rem_r[k]  <= ge ? (rem_in - trial) : rem_in;
      sq_root_r[k] <= {proot[ROOT_W-2:0], ge};
      sq_n_r[k]    <= pn << 2;
      sq_pay_r[k]  <= ppay;
    end
  end

  // Reciprocal 2^(2F-1) / s, one quotient bit per stage.
  logic              dv_valid_r [Q_W];
  logic [ROOT_W:0]   dv_rem_r   [Q_W];
  logic [Q_W-1:0]    dv_q_r     [Q_W];
  logic [ROOT_W-1:0] dv_s_r     [Q_W];
  logic [PW-1:0]     dv_pay_r   [Q_W];

  for (k = 0; k < Q_W; k++) begin : g_div
    logic              pv;
    logic [ROOT_W:0]   prem, rem_in;
    logic [Q_W-1:0]    pq;
    logic [ROOT_W-1:0] ps;
    logic [PW-1:0]     ppay;
    logic              ge;
    if (k == 0) begin : g_first
      assign pv   = sq_valid_r[ROOT_W-1];
      assign prem = '0;
      assign pq   = '0;
      assign ps   = sq_root_r[ROOT_W-1];
      assign ppay = sq_pay_r[ROOT_W-1];
    end else begin : g_next
      assign pv   = dv_valid_r[k-1];
      assign prem = dv_rem_r[k-1];
      assign pq   = dv_q_r[k-1];
      assign ps   = dv_s_r[k-1];
      assign ppay = dv_pay_r[k-1];
    end
    assign rem_in = {prem[ROOT_W-1:0], (k == 0) ? 1'b1 : 1'b0};
    assign ge     = (rem_in >= {1'b0, ps});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[k] <= 1'b0;
      end else begin
        dv_valid_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      dv_rem_r[k] <= ge ? (rem_in - {1'b0, ps}) : rem_in;
      dv_q_r[k]   <= {pq[Q_W-2:0], ge};
      dv_s_r[k]   <= ps;
      dv_pay_r[k] <= ppay;
    end
  end

  // Scaling multipliers on magnitudes.
  logic [ROOT_W-1:0] fin_s;
  logic [Q_W-1:0]    fin_r;
  logic [PW-1:0]     fin_pay;
  logic              mul_valid_r;
  logic [PR_W-1:0]   mul_prod_r [4];
  logic              mul_neg_r  [4];
  logic [ROOT_W-2:0] mul_half_r;
  axis_t             mul_pos_r;

  assign fin_s   = dv_s_r[Q_W-1];
  assign fin_pay = dv_pay_r[Q_W-1];
  // A zero root skips the reciprocal.
  assign fin_r   = (fin_s == '0) ? '0 : dv_q_r[Q_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else begin
      mul_valid_r <= dv_valid_r[Q_W-1];
    end
  end

  for (k = 0; k < 4; k++) begin : g_mul
    logic signed [VW-1:0] vs;
    logic [VW-1:0]        mag;
    assign vs  = fin_pay[k*VW +: VW];
    assign mag = vs[VW-1] ? (VW'(0) - vs) : vs;
    always_ff @(posedge clk) begin
      mul_prod_r[k] <= PR_W'(mag) * PR_W'(fin_r);
      mul_neg_r[k]  <= vs[VW-1];
    end
  end

  always_ff @(posedge clk) begin
    mul_half_r <= fin_s[ROOT_W-1:1];
    mul_pos_r  <= axis_t'(fin_pay[PW-1 -: 2]);
  end

  // Truncate, restore the sign and saturate; the root slot takes half the root.
  logic                         out_valid_r;
  logic signed [DATA_WIDTH-1:0] out_q_r   [4];
  logic signed [DATA_WIDTH-1:0] out_q_nxt [4];

  always_comb begin
    logic [63:0] shw, neg64, h64;
    for (int j = 0; j < 4; j++) begin
      shw   = 64'(mul_prod_r[j] >> FRAC_BITS);
      neg64 = 64'd0 - shw;
      h64   = 64'(mul_half_r);
      if (2'(j) == mul_pos_r) begin
        out_q_nxt[j] = (h64 > MAXP) ? DATA_WIDTH'(MAXP) : DATA_WIDTH'(h64);
      end else if (mul_neg_r[j]) begin
        out_q_nxt[j] = (shw > MAXP + 64'd1) ? ~DATA_WIDTH'(MAXP) : DATA_WIDTH'(neg64);
      end else begin
        out_q_nxt[j] = (shw > MAXP) ? DATA_WIDTH'(MAXP) : DATA_WIDTH'(shw);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= mul_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) out_q_r[j] <= out_q_nxt[j];
  end

  assign out_valid  = out_valid_r;
  assign out_quat_x = out_q_r[AXIS_X];
  assign out_quat_y = out_q_r[AXIS_Y];
  assign out_quat_z = out_q_r[AXIS_Z];
  assign out_quat_w = out_q_r[AXIS_W];

endmodule

@@ hw/rtl/rotation_matrix_to_quaternion.sv @@
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation matrix in signed fixed point to its quaternion
// with the Shoemake method.
// ---------------------------------------------------------------------------
//
//   Channel | Ports                       | Handshake
//   --------+-----------------------------+-------------------------------
//   input   | start, busy, in_m00..in_m22 | beat taken when start && !busy
//   result  | out_valid, out_quat_x..w    | strobe, one cycle, no backpressure
//
// One beat can be taken every cycle while busy is low. The square root has
// R = ceil((max(DATA_WIDTH,FRAC_BITS) + 3 + FRAC_BITS) / 2) stages (17 with
// the defaults); it and the reciprocal are pipelines that produce one result
// bit per stage. Reset is synchronous and clears every valid flag and the
// queue. The result side cannot stall, so the back end drains the queue
// every cycle and busy stays low in normal use.
//
// The front end picks the branch (positive trace, or the largest diagonal
// entry with earlier entries winning ties), builds the radicand and the three
// numerators, and hands the item to a short queue. The back end takes the
// square root of the radicand, the truncated reciprocal 0.5/s, scales the
// numerators by it with truncation toward zero, and saturates.
module rotation_matrix_to_quaternion #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_m00,
  input  logic signed [DATA_WIDTH-1:0] in_m01,
  input  logic signed [DATA_WIDTH-1:0] in_m02,
  input  logic signed [DATA_WIDTH-1:0] in_m10,
  input  logic signed [DATA_WIDTH-1:0] in_m11,
  input  logic signed [DATA_WIDTH-1:0] in_m12,
  input  logic signed [DATA_WIDTH-1:0] in_m20,
  input  logic signed [DATA_WIDTH-1:0] in_m21,
  input  logic signed [DATA_WIDTH-1:0] in_m22,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_quat_x,
  output logic signed [DATA_WIDTH-1:0] out_quat_y,
  output logic signed [DATA_WIDTH-1:0] out_quat_z,
  output logic signed [DATA_WIDTH-1:0] out_quat_w
);
  import rmq_pkg::*;

  localparam int IW = item_width(DATA_WIDTH, FRAC_BITS);

  logic          q_full, front_valid, head_valid;
  logic [IW-1:0] front_item, head_item;

  // A beat is refused only while the queue is full; the front register then
  // holds its item until the queue has room.
  assign busy = q_full;

  rmq_front #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (start && !busy),
    .hold      (q_full),
    .in_m00    (in_m00),
    .in_m01    (in_m01),
    .in_m02    (in_m02),
    .in_m10    (in_m10),
    .in_m11    (in_m11),
    .in_m12    (in_m12),
    .in_m20    (in_m20),
    .in_m21    (in_m21),
    .in_m22    (in_m22),
    .item_valid(front_valid),
    .item      (front_item)
  );

  rmq_queue #(
    .IW(IW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_valid),
    .push_item (front_item),
    .pop       (1'b1),
    .full      (q_full),
    .head_valid(head_valid),
    .head_item (head_item)
  );

  // The back end never stalls, so it takes the queue head whenever present.
  rmq_back #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(head_valid),
    .item      (head_item),
    .out_valid (out_valid),
    .out_quat_x(out_quat_x),
    .out_quat_y(out_quat_y),
    .out_quat_z(out_quat_z),
    .out_quat_w(out_quat_w)
  );

endmodule

@@ hw/rtl/rmq_checker.sv @@
// ---------------------------------------------------------------------------
// rmq_checker
// Port-level checks of the quaternion block, bound to its top level.
// ---------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_assert.svh"

module rmq_checker #(
  parameter int LAT = 4
) (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // Reset leaves nothing in flight and the input open.
  `RMQ_ASSERT_NEXT(a_reset_quiet, !rst_n, !out_valid && !busy)

  // Every taken beat produces its result after the fixed latency.
  `RMQ_ASSERT_DELAY(a_result_follows, start && !busy, LAT, out_valid)

  // No result appears without a beat taken the latency earlier.
  `RMQ_ASSERT_IMPLY(a_no_phantom, out_valid, $past(start && !busy && rst_n, LAT))

  // With a receiver that never stalls the input is never refused.
  `RMQ_ASSERT_IMPLY(a_never_busy, 1'b1, !busy)

endmodule

bind rotation_matrix_to_quaternion rmq_checker #(
  .LAT(rmq_pkg::latency(DATA_WIDTH, FRAC_BITS))
) u_rmq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid)
);
